// ===== sv/mcs_pkg.sv =====
// Shared types, constants and helpers for the mask centroid smoother.
package mcs_pkg;

    // Default geometry of the pixel stream and the filter precision.
    localparam int DEF_COORD_BITS = 10;
    localparam int DEF_FRAC_BITS  = 8;

    // Mask pixel width on the input stream.
    localparam int PIXEL_W = 8;

    // Smoothing gains are Q0.8 values; one extra bit holds the value one.
    localparam int GAIN_BITS = 8;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE        = GAIN_W'(1 << GAIN_BITS);
    localparam logic [GAIN_W-1:0] POS_GAIN_RESET  = GAIN_W'(128);
    localparam logic [GAIN_W-1:0] AREA_GAIN_RESET = GAIN_W'(26);

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_GAIN = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_AREA_GAIN     = CFG_INDEX_W'(1);

    // Status of the iterative divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Command to the shared multiply-accumulate unit.
    typedef struct packed {
        logic issue;
        logic first;
    } mac_cmd_t;

    // Gains above one are taken as one.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

// ===== sv/mcs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module mcs_div
    import mcs_pkg::*;
#(
    parameter int NUM_W = 30,
    parameter int DEN_W = 21,
    parameter int Q_W   = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output div_stat_t        stat,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   bits_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // The caller guarantees the quotient fits in Q_W bits, so the upper part
    // of the numerator is already below the divisor and only Q_W steps remain.
    assign trial = {rem_reg, bits_reg[Q_W-1]};
    assign fits  = (trial >= {1'b0, denom});
    assign diff  = trial - {1'b0, denom};

    // Step counter and handshake flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= DEN_W'(numer[NUM_W-1:Q_W]);
            bits_reg <= numer[Q_W-1:0];
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            bits_reg <= {bits_reg[Q_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = bits_reg;

endmodule

// ===== sv/mcs_mac.sv =====
// Shared multiplier with a registered product and an accumulator behind it.
module mcs_mac
    import mcs_pkg::*;
#(
    parameter int A_W = 9,
    parameter int B_W = 29
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mac_cmd_t           cmd,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] acc
);

    logic [A_W+B_W-1:0] prod_reg;
    logic [A_W+B_W-1:0] acc_reg;
    logic               issue_reg;
    logic               first_reg;

    // Stage flags follow the product through the register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            issue_reg <= cmd.issue;
            first_reg <= cmd.first;
        end
    end

    // Multiply into the product register, then load or add it into the accumulator in the next cycle.
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            prod_reg <= a * b;
        end
        if (issue_reg) begin
            acc_reg <= first_reg ? prod_reg : acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== sv/mask_centroid_smoother_core.sv =====
// Mask centroid with exponential smoothing of position and area.
//
// Pixels enter on the s_ stream, one per cycle while s_tready is high, each
// with its column and row; s_tlast marks the last pixel of a frame. Nonzero
// pixels are counted and their coordinates summed as they arrive.
// After the last pixel is taken, s_tready drops while a sequencer runs the
// frame-end work: two divisions on one shift-subtract divider (one quotient
// bit per cycle), then three filter updates on one shared multiplier. An
// empty frame skips the arithmetic and goes straight to the done state.
// The result sits in an output register; pixels of the next frame are taken
// while it waits, and only the next frame's end stalls until m_tready takes it.
// The user writes the gains on the cfg_ channel only between frames; the block
// does not enforce it. Reset clears the accumulators and filters, sets the
// gains to one half and about one tenth, and drops m_tvalid.
module mask_centroid_smoother_core
    import mcs_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int IN_W      = ((PIXEL_W + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((1 + 6 * COORD_BITS + 3 * FRAC_BITS + 1 + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Pixel stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,   // pixel_value, column, row
    input  logic                   s_tlast,   // last_in_frame
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // found, centroid_x, centroid_y,
                                              // smoothed_x, smoothed_y, smoothed_area
    // Register writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data
);

    localparam int COUNT_W = 2 * COORD_BITS + 1;
    localparam int SUM_W   = 3 * COORD_BITS;
    localparam int POS_W   = COORD_BITS + FRAC_BITS;
    localparam int AREA_W  = 2 * COORD_BITS + FRAC_BITS + 1;
    localparam int ACC_W   = GAIN_W + AREA_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIV_X_GO  = 3'd1;
    localparam logic [2:0] ST_DIV_X_WT  = 3'd2;
    localparam logic [2:0] ST_DIV_Y_GO  = 3'd3;
    localparam logic [2:0] ST_DIV_Y_WT  = 3'd4;
    localparam logic [2:0] ST_FILTER    = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    // Filter being updated.
    localparam logic [1:0] SEL_X    = 2'd0;
    localparam logic [1:0] SEL_Y    = 2'd1;
    localparam logic [1:0] SEL_AREA = 2'd2;

    // Steps of one filter update.
    localparam logic [1:0] STEP_NEW   = 2'd0;
    localparam logic [1:0] STEP_OLD   = 2'd1;
    localparam logic [1:0] STEP_WRITE = 2'd3;

    logic [2:0]            state_reg;
    logic [1:0]            sel_reg;
    logic [1:0]            step_reg;

    logic [GAIN_W-1:0]     pos_gain_reg;
    logic [GAIN_W-1:0]     area_gain_reg;

    logic [COUNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]      col_sum_reg;
    logic [SUM_W-1:0]      row_sum_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [SUM_W-1:0]      col_sum_next;
    logic [SUM_W-1:0]      row_sum_next;

    logic [POS_W-1:0]      filt_col_reg;
    logic [POS_W-1:0]      filt_row_reg;
    logic [AREA_W-1:0]     filt_count_reg;

    logic                  found_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;

    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    logic [PIXEL_W-1:0]    pix;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  in_acc;
    logic                  take;
    logic                  out_free;

    logic                  div_start;
    logic [SUM_W-1:0]      div_numer;
    div_stat_t             div_stat;
    logic [COORD_BITS-1:0] div_quot;

    mac_cmd_t              mac_cmd;
    logic [GAIN_W-1:0]     gain_sel;
    logic [GAIN_W-1:0]     mac_a;
    logic [AREA_W-1:0]     mac_b;
    logic [AREA_W-1:0]     value_ext;
    logic [AREA_W-1:0]     old_ext;
    logic [ACC_W-1:0]      mac_acc;
    logic [ACC_W-1:0]      filt_new;

    // Input unpacking and handshake.
    assign pix      = s_tdata[PIXEL_W-1:0];
    assign col      = s_tdata[PIXEL_W +: COORD_BITS];
    assign row      = s_tdata[PIXEL_W + COORD_BITS +: COORD_BITS];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Object pixels are counted until the count reaches a full frame.
    assign take         = in_acc && (pix != '0) && !count_reg[COUNT_W-1];
    assign count_next   = take ? count_reg + 1'b1 : count_reg;
    assign col_sum_next = take ? col_sum_reg + SUM_W'(col) : col_sum_reg;
    assign row_sum_next = take ? row_sum_reg + SUM_W'(row) : row_sum_reg;

    // Gain registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_gain_reg  <= POS_GAIN_RESET;
            area_gain_reg <= AREA_GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_POSITION_GAIN: pos_gain_reg  <= cfg_data;
                REG_AREA_GAIN:     area_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared divider: column sum first, then row sum, both over the count.
    assign div_start = (state_reg == ST_DIV_X_GO) || (state_reg == ST_DIV_Y_GO);
    assign div_numer = (state_reg == ST_DIV_Y_GO) ? row_sum_reg : col_sum_reg;

    mcs_div #(
        .NUM_W (SUM_W),
        .DEN_W (COUNT_W),
        .Q_W   (COORD_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (count_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // Operand selection for the shared multiplier: gain times new value,
    // then the complement of the gain times the old filter value.
    always_comb begin
        case (sel_reg)
            SEL_X: begin
                value_ext = AREA_W'({cx_reg, {FRAC_BITS{1'b0}}});
                old_ext   = AREA_W'(filt_col_reg);
                gain_sel  = clamp_gain(pos_gain_reg);
            end
            SEL_Y: begin
                value_ext = AREA_W'({cy_reg, {FRAC_BITS{1'b0}}});
                old_ext   = AREA_W'(filt_row_reg);
                gain_sel  = clamp_gain(pos_gain_reg);
            end
            SEL_AREA: begin
                value_ext = AREA_W'({count_reg, {FRAC_BITS{1'b0}}});
                old_ext   = filt_count_reg;
                gain_sel  = clamp_gain(area_gain_reg);
            end
            default: begin
                value_ext = '0;
                old_ext   = '0;
                gain_sel  = '0;
            end
        endcase
    end

    assign mac_cmd.issue = (state_reg == ST_FILTER) &&
                           ((step_reg == STEP_NEW) || (step_reg == STEP_OLD));
    assign mac_cmd.first = (step_reg == STEP_NEW);
    assign mac_a         = (step_reg == STEP_NEW) ? gain_sel : GAIN_ONE - gain_sel;
    assign mac_b         = (step_reg == STEP_NEW) ? value_ext : old_ext;
    assign filt_new      = mac_acc >> GAIN_BITS;

    mcs_mac #(
        .A_W (GAIN_W),
        .B_W (AREA_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .a       (mac_a),
        .b       (mac_b),
        .acc     (mac_acc)
    );

    // Sequencer, accumulators and filter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sel_reg        <= SEL_X;
            step_reg       <= STEP_NEW;
            count_reg      <= '0;
            col_sum_reg    <= '0;
            row_sum_reg    <= '0;
            filt_col_reg   <= '0;
            filt_row_reg   <= '0;
            filt_count_reg <= '0;
            found_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        count_reg   <= count_next;
                        col_sum_reg <= col_sum_next;
                        row_sum_reg <= row_sum_next;
                        if (s_tlast) begin
                            found_reg <= (count_next != '0);
                            state_reg <= (count_next != '0) ? ST_DIV_X_GO : ST_DONE;
                        end
                    end
                end
                ST_DIV_X_GO: state_reg <= ST_DIV_X_WT;
                ST_DIV_X_WT: begin
                    if (div_stat.done) begin
                        state_reg <= ST_DIV_Y_GO;
                    end
                end
                ST_DIV_Y_GO: state_reg <= ST_DIV_Y_WT;
                ST_DIV_Y_WT: begin
                    if (div_stat.done) begin
                        sel_reg   <= SEL_X;
                        step_reg  <= STEP_NEW;
                        state_reg <= ST_FILTER;
                    end
                end
                ST_FILTER: begin
                    if (step_reg == STEP_WRITE) begin
                        case (sel_reg)
                            SEL_X:    filt_col_reg   <= POS_W'(filt_new);
                            SEL_Y:    filt_row_reg   <= POS_W'(filt_new);
                            default:  filt_count_reg <= AREA_W'(filt_new);
                        endcase
                        step_reg <= STEP_NEW;
                        if (sel_reg == SEL_AREA) begin
                            state_reg <= ST_DONE;
                        end else begin
                            sel_reg <= sel_reg + 1'b1;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        count_reg   <= '0;
                        col_sum_reg <= '0;
                        row_sum_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Centroid registers: quotients, or zero for an empty frame.
    always_ff @(posedge aclk) begin
        if (in_acc && s_tlast) begin
            cx_reg <= '0;
            cy_reg <= '0;
        end else if (state_reg == ST_DIV_X_WT && div_stat.done) begin
            cx_reg <= div_quot;
        end else if (state_reg == ST_DIV_Y_WT && div_stat.done) begin
            cy_reg <= div_quot;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= OUT_W'({filt_count_reg, filt_row_reg, filt_col_reg,
                                   cy_reg, cx_reg, found_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV_X_WT || state_reg == ST_DIV_Y_WT))
        else $error("divider finished outside a wait state");

    // Filter updates run only for frames with object pixels.
    a_filter_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILTER) |-> (count_reg != '0) && found_reg)
        else $error("filter update on an empty frame");

    // The end of a frame always leaves the idle state.
    a_last_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (state_reg != ST_IDLE))
        else $error("frame end did not start the sequencer");

    // The pixel count never passes one full frame.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        !count_reg[COUNT_W-1] || (count_reg[COUNT_W-2:0] == '0))
        else $error("object pixel count beyond a full frame");

    // An empty frame reports a zero centroid.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[0]) |->
            (m_tdata_reg[2*COORD_BITS:1] == '0))
        else $error("empty frame with a nonzero centroid");

endmodule
